@@ src/tsm_pkg.sv @@
`default_nettype none

package tsm_pkg;

	// Field and port widths fixed by the item formats.
	localparam int KIND_W      = 2;
	localparam int ADDR_W      = 12;
	localparam int BYTE_W      = 8;
	localparam int PLEN_W      = 9;
	localparam int TLEN_W      = 13;
	localparam int COUNT_W     = 13;
	localparam int WORD_W      = 64;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - COUNT_W - WORD_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	localparam int PATTERN_MAX_DEF = 256;
	localparam int TEXT_MAX_DEF    = 4096;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAT  = 2'd0,
		KIND_TEXT = 2'd1,
		KIND_RUN  = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLEN = 1'b0,
		CFG_TLEN = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_RUN,
		T_READ
	} top_state_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_CLEAR,
		E_HEAD,
		E_PROBE,
		E_VER_RD,
		E_VER_CMP,
		E_MARK_RD,
		E_MARK_WR,
		E_AFTER,
		E_H_CHK,
		E_H_CMP,
		E_H_DONE,
		E_DONE
	} eng_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

endpackage

`default_nettype wire

@@ src/tsm_ram.sv @@
`default_nettype none

module tsm_ram import tsm_pkg::*; #(
	parameter int DEPTH = TEXT_MAX_DEF,
	parameter int WIDTH = BYTE_W,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/tsm_engine.sv @@
`default_nettype none

module tsm_engine import tsm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = TEXT_MAX_DEF,
	parameter int PAW         = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
	parameter int TAW         = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1,
	parameter int MW          = (((TEXT_MAX + 63) / 64) > 1) ? $clog2((TEXT_MAX + 63) / 64) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [PLEN_W-1:0]  plen,
	input  wire logic [TLEN_W-1:0]  tlen,
	output logic                    pat_re,
	output logic      [PAW-1:0]     pat_raddr,
	input  wire logic [BYTE_W-1:0]  pat_rdata,
	output logic                    txt_re,
	output logic      [TAW-1:0]     txt_raddr,
	input  wire logic [BYTE_W-1:0]  txt_rdata,
	output logic                    bm_re,
	output logic                    bm_we,
	output logic      [MW-1:0]      bm_addr,
	output logic      [WORD_W-1:0]  bm_wdata,
	input  wire logic [WORD_W-1:0]  bm_rdata,
	output logic      [COUNT_W-1:0] found_total,
	output eng_stat_t               stat
);

	localparam int MAP_WORDS = (TEXT_MAX + 63) / 64;
	localparam int SUMW      = $clog2(TEXT_MAX + PATTERN_MAX + 2);
	localparam int LW        = (SUMW > TLEN_W) ? SUMW : TLEN_W;
	localparam int LW1       = LW + 1;

	localparam logic signed [LW:0] ZERO   = '0;
	localparam logic signed [LW:0] ONE    = LW1'(1);
	localparam logic signed [LW:0] PMAX_S = LW1'(PATTERN_MAX);
	localparam logic signed [LW:0] TMAX_S = LW1'(TEXT_MAX);
	localparam logic [MW-1:0]      CW_LAST = MW'(MAP_WORDS - 1);

	eng_state_t state_q, state_d;

	// Scan registers: window start, phase-one index, tail index, shift
	// distance, back-scan index, verify index, clamped lengths.
	logic signed [LW:0] s_q, i_q, k_q, dim_q, h_q, j_q, m_q, n_q;
	logic [MW-1:0]      cw_q;
	logic [BYTE_W-1:0]  tb_q;
	logic               p1_q;
	logic [COUNT_W-1:0] count_q;

	logic signed [LW:0] m_w, n_w, probe_idx, pidx, tpos, back_dist;
	logic               p1_now, in_range, bytes_eq, bit_set, ver_last;
	logic [WORD_W-1:0]  bitmask;

	always_comb begin
		m_w       = (32'(plen) > PATTERN_MAX) ? PMAX_S : LW1'(plen);
		n_w       = (32'(tlen) > TEXT_MAX) ? TMAX_S : LW1'(tlen);
		p1_now    = (i_q - dim_q) >= ZERO;
		in_range  = (s_q + m_q) <= n_q;
		probe_idx = p1_now ? i_q : k_q;
		pidx      = (state_q == E_VER_RD) ? j_q : probe_idx;
		tpos      = s_q + pidx;
		back_dist = i_q - h_q;
		bytes_eq  = pat_rdata == txt_rdata;
		ver_last  = j_q == (m_q - ONE);
		bitmask   = WORD_W'(1) << s_q[5:0];
		bit_set   = |(bm_rdata & bitmask);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE: begin
				if (start) begin
					state_d = E_CLEAR;
				end
			end
			E_CLEAR: begin
				if (cw_q == CW_LAST) begin
					state_d = ((m_q == ZERO) || (m_q > n_q)) ? E_DONE : E_HEAD;
				end
			end
			E_HEAD:    state_d = in_range ? E_PROBE : E_DONE;
			E_PROBE:   state_d = bytes_eq ? E_VER_RD : E_HEAD;
			E_VER_RD:  state_d = E_VER_CMP;
			E_VER_CMP: begin
				if (!bytes_eq) begin
					state_d = E_AFTER;
				end else if (ver_last) begin
					state_d = E_MARK_RD;
				end else begin
					state_d = E_VER_RD;
				end
			end
			E_MARK_RD: state_d = E_MARK_WR;
			E_MARK_WR: state_d = E_AFTER;
			E_AFTER:   state_d = p1_q ? E_H_CHK : E_HEAD;
			E_H_CHK:   state_d = (h_q < ZERO) ? E_H_DONE : E_H_CMP;
			E_H_CMP:   state_d = (pat_rdata == tb_q) ? E_H_DONE : E_H_CHK;
			E_H_DONE:  state_d = E_HEAD;
			E_DONE:    state_d = E_IDLE;
			default:   state_d = E_IDLE;
		endcase
	end

	// Memory ports and status.
	always_comb begin
		pat_re    = 1'b0;
		pat_raddr = pidx[PAW-1:0];
		txt_re    = 1'b0;
		txt_raddr = tpos[TAW-1:0];
		bm_re     = 1'b0;
		bm_we     = 1'b0;
		bm_addr   = s_q[MW+5:6];
		bm_wdata  = bm_rdata | bitmask;
		case (state_q)
			E_CLEAR: begin
				bm_we    = 1'b1;
				bm_addr  = cw_q;
				bm_wdata = '0;
			end
			E_HEAD: begin
				pat_re = in_range;
				txt_re = in_range;
			end
			E_VER_RD: begin
				pat_re = 1'b1;
				txt_re = 1'b1;
			end
			E_MARK_RD: bm_re = 1'b1;
			E_MARK_WR: bm_we = !bit_set;
			E_H_CHK: begin
				pat_re    = h_q >= ZERO;
				pat_raddr = h_q[PAW-1:0];
			end
			default: begin
			end
		endcase
		stat.busy   = state_q != E_IDLE;
		stat.done   = state_q == E_DONE;
		found_total = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == E_IDLE) && start) begin
				count_q <= '0;
			end else if ((state_q == E_MARK_WR) && !bit_set) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				if (start) begin
					m_q  <= m_w;
					n_q  <= n_w;
					cw_q <= '0;
				end
			end
			E_CLEAR: begin
				cw_q <= cw_q + MW'(1);
				if (cw_q == CW_LAST) begin
					s_q   <= ZERO;
					i_q   <= m_q - ONE;
					k_q   <= m_q - ONE;
					dim_q <= ONE;
				end
			end
			E_HEAD: p1_q <= p1_now;
			E_PROBE: begin
				if (!bytes_eq) begin
					s_q <= s_q + ONE;
				end else begin
					j_q  <= ZERO;
					tb_q <= pat_rdata;
				end
			end
			E_VER_CMP: begin
				if (bytes_eq && !ver_last) begin
					j_q <= j_q + ONE;
				end
			end
			E_AFTER: begin
				if (p1_q) begin
					h_q <= i_q - ONE;
				end else begin
					s_q <= s_q + dim_q;
				end
			end
			E_H_CMP: begin
				if (pat_rdata != tb_q) begin
					h_q <= h_q - ONE;
				end
			end
			E_H_DONE: begin
				if (dim_q < back_dist) begin
					k_q   <= i_q;
					dim_q <= back_dist;
				end
				s_q <= s_q + back_dist;
				i_q <= i_q - ONE;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> !stat.done)
		else $error("run completion lasted more than one cycle");

	a_mark_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_MARK_WR) |-> ($past(state_q) == E_MARK_RD))
		else $error("bitmap update without a preceding word read");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != E_IDLE) |=> ((count_q == $past(count_q))
			|| (count_q == $past(count_q) + COUNT_W'(1)) || (count_q == '0)))
		else $error("match count moved by more than one");

	a_verify_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_VER_CMP) |-> ((j_q >= ZERO) && (j_q < m_q)))
		else $error("verify index left the pattern");
`endif

endmodule

`default_nettype wire

@@ src/tailed_substring_matcher_core.sv @@
`default_nettype none

// Exact string matcher using the tailed substring method. Pattern and text
// bytes are loaded by address (tuser selects the item kind), and a run item
// clears the 64-bit-word match bitmap, scans the text and returns the number
// of occurrences; a read item returns one bitmap word. Every input
// transaction yields exactly one output transaction. Writes answer through
// the output register, in-range reads also through the registered bitmap
// read. A run sweeps the bitmap at one word per cycle ((TEXT_MAX + 63) / 64
// words, 64 at the defaults), then per text probe reads and compares a
// pattern and a text byte, reads and compares each candidate window byte in
// turn, closes each candidate window, and records a match by reading its
// bitmap word and writing it back with the bit set if it was clear. In
// phase one the back scan compares pattern bytes until it meets the probed
// byte again or runs off the front of the pattern, then applies the shift.
// A final range check and a completion state end the run. The single read
// port of each memory sets all of this. Until the first run after reset,
// the bitmap reads as zero through a flag, so reset needs no clearing
// pass. Lengths are taken from the configuration port when the run starts;
// the port must only be written while no transaction is in flight.
module tailed_substring_matcher_core import tsm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = TEXT_MAX_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// address [11:0], byte_value [19:12], zero [23:20]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind [1:0]
	input  wire logic [KIND_W-1:0]      s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// status [0], match_count [13:1], match_word [77:14], zero [79:78]
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int MAP_WORDS = (TEXT_MAX + 63) / 64;
	localparam int PAW       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int TAW       = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
	localparam int MW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	top_state_t state_q, state_d;

	logic [PLEN_W-1:0]  plen_q;
	logic [TLEN_W-1:0]  tlen_q;
	logic               ever_run_q;
	logic               out_valid_q;
	logic               out_status_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [WORD_W-1:0]  out_word_q;

	// Input transaction fields.
	kind_t             kind;
	logic [ADDR_W-1:0] addr;
	logic [BYTE_W-1:0] byte_value;
	logic              accept;
	logic              pat_ok, txt_ok, map_ok;

	// Result load controls.
	logic              load;
	logic              ld_status;
	logic [WORD_W-1:0] ld_word;
	logic              start;
	logic              host_rd;

	// Memory ports.
	logic               pat_re, txt_re;
	logic [PAW-1:0]     pat_raddr;
	logic [TAW-1:0]     txt_raddr;
	logic [BYTE_W-1:0]  pat_rdata, txt_rdata;
	logic               eng_bm_re, eng_bm_we;
	logic [MW-1:0]      eng_bm_addr;
	logic [WORD_W-1:0]  eng_bm_wdata;
	logic               bm_re;
	logic [MW-1:0]      bm_addr;
	logic [WORD_W-1:0]  bm_rdata;
	logic [COUNT_W-1:0] found_total;
	eng_stat_t          eng_stat;

	always_comb begin
		kind       = kind_t'(s_axis_tuser);
		addr       = s_axis_tdata[ADDR_W-1:0];
		byte_value = s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W];
		pat_ok     = 32'(addr) < PATTERN_MAX;
		txt_ok     = 32'(addr) < TEXT_MAX;
		map_ok     = 32'(addr) < MAP_WORDS;
	end

	// Next state: runs wait for the engine, in-range reads for the bitmap
	// memory; everything else answers in the cycle it is accepted.
	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: begin
				if (accept && (kind == KIND_RUN)) begin
					state_d = T_RUN;
				end else if (accept && (kind == KIND_READ) && map_ok) begin
					state_d = T_READ;
				end
			end
			T_RUN: begin
				if (eng_stat.done) begin
					state_d = T_IDLE;
				end
			end
			T_READ:  state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	// Handshake and result selection. A new transaction is taken in the idle
	// state whenever the output register is empty or being emptied in this cycle.
	always_comb begin
		s_axis_tready = (state_q == T_IDLE) && (!out_valid_q || m_axis_tready);
		accept        = s_axis_tvalid && s_axis_tready;
		start         = accept && (kind == KIND_RUN);
		host_rd       = accept && (kind == KIND_READ) && map_ok;
		load          = 1'b0;
		ld_status     = 1'b0;
		ld_word       = '0;
		case (state_q)
			T_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_PAT: begin
							load      = 1'b1;
							ld_status = !pat_ok;
						end
						KIND_TEXT: begin
							load      = 1'b1;
							ld_status = !txt_ok;
						end
						KIND_READ: begin
							load      = !map_ok;
							ld_status = !map_ok;
						end
						default: begin
						end
					endcase
				end
			end
			T_RUN: load = eng_stat.done;
			T_READ: begin
				load    = 1'b1;
				ld_word = ever_run_q ? bm_rdata : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			plen_q      <= PLEN_W'(1);
			tlen_q      <= '0;
			ever_run_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PLEN: plen_q <= cfg_data[PLEN_W-1:0];
					CFG_TLEN: tlen_q <= cfg_data[TLEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (start) begin
				ever_run_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_count_q  <= found_total;
			out_word_q   <= ld_word;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {OUT_PAD_W'(0), out_word_q, out_count_q, out_status_q};

	// The engine owns the bitmap port during a run; otherwise the host
	// read uses it.
	always_comb begin
		bm_re   = eng_stat.busy ? eng_bm_re : host_rd;
		bm_addr = eng_stat.busy ? eng_bm_addr : MW'(addr);
	end

	tsm_ram #(
		.DEPTH (PATTERN_MAX),
		.WIDTH (BYTE_W),
		.AW    (PAW)
	) u_pattern_ram (
		.clk   (clk),
		.we    (accept && (kind == KIND_PAT) && pat_ok),
		.waddr (PAW'(addr)),
		.wdata (byte_value),
		.re    (pat_re),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	tsm_ram #(
		.DEPTH (TEXT_MAX),
		.WIDTH (BYTE_W),
		.AW    (TAW)
	) u_text_ram (
		.clk   (clk),
		.we    (accept && (kind == KIND_TEXT) && txt_ok),
		.waddr (TAW'(addr)),
		.wdata (byte_value),
		.re    (txt_re),
		.raddr (txt_raddr),
		.rdata (txt_rdata)
	);

	tsm_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_W),
		.AW    (MW)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (eng_bm_we),
		.waddr (eng_bm_addr),
		.wdata (eng_bm_wdata),
		.re    (bm_re),
		.raddr (bm_addr),
		.rdata (bm_rdata)
	);

	tsm_engine #(
		.PATTERN_MAX (PATTERN_MAX),
		.TEXT_MAX    (TEXT_MAX),
		.PAW         (PAW),
		.TAW         (TAW),
		.MW          (MW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.plen        (plen_q),
		.tlen        (tlen_q),
		.pat_re      (pat_re),
		.pat_raddr   (pat_raddr),
		.pat_rdata   (pat_rdata),
		.txt_re      (txt_re),
		.txt_raddr   (txt_raddr),
		.txt_rdata   (txt_rdata),
		.bm_re       (eng_bm_re),
		.bm_we       (eng_bm_we),
		.bm_addr     (eng_bm_addr),
		.bm_wdata    (eng_bm_wdata),
		.bm_rdata    (bm_rdata),
		.found_total (found_total),
		.stat        (eng_stat)
	);

endmodule

`default_nettype wire

@@ tb/tsm_search_checker.sv @@
`default_nettype none

// Watches both stream channels and the configuration port, keeps its own
// copy of the stores, the bitmap and the lengths, and compares every reply
// with the oldest predicted one.
module tsm_search_checker import tsm_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	input  wire logic                   s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic [KIND_W-1:0]      s_axis_tuser,
	input  wire logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  MAP_WORDS   = (TEXT_MAX_DEF + 63) / 64;
	localparam int  REPORT_MAX  = 10;
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_RANGE   = 1'b1;

	typedef struct packed {
		logic               status;
		logic [COUNT_W-1:0] count;
		logic [WORD_W-1:0]  word;
	} reply_t;

	logic [BYTE_W-1:0]  pat_mem [PATTERN_MAX_DEF];
	logic [BYTE_W-1:0]  txt_mem [TEXT_MAX_DEF];
	logic [WORD_W-1:0]  hit_map [MAP_WORDS];
	logic [COUNT_W-1:0] hit_total;
	logic [PLEN_W-1:0]  pat_len;
	logic [TLEN_W-1:0]  txt_len;
	reply_t             reply_q [$];
	int                 miss_total;

	function automatic bit window_equal(input int s, input int m);
		for (int j = 0; j < m; j++)
			if (pat_mem[j] != txt_mem[s + j])
				return 1'b0;
		return 1'b1;
	endfunction

	// A start already flagged is not counted a second time.
	function automatic void mark_start(input int pos);
		if (!hit_map[pos >> 6][pos & 63]) begin
			hit_map[pos >> 6][pos & 63] = 1'b1;
			hit_total = hit_total + 1'b1;
		end
	endfunction

	function automatic void scan_text();
		int m, n, s, i, k, h, span;
		m = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
		n = (txt_len > TEXT_MAX_DEF) ? TEXT_MAX_DEF : int'(txt_len);
		foreach (hit_map[w])
			hit_map[w] = '0;
		hit_total = '0;
		if (m == 0 || m > n)
			return;
		// Learn the longest tailed substring while scanning.
		s = 0;
		i = m - 1;
		k = m - 1;
		span = 1;
		while (s <= n - m && i - span >= 0) begin
			if (pat_mem[i] != txt_mem[s + i]) begin
				s++;
			end else begin
				if (window_equal(s, m))
					mark_start(s);
				h = i - 1;
				while (h >= 0 && pat_mem[h] != pat_mem[i])
					h--;
				if (span < i - h) begin
					k = i;
					span = i - h;
				end
				s += i - h;
				i--;
			end
		end
		// Probe only the tail byte and jump by the substring length.
		while (s <= n - m) begin
			if (pat_mem[k] != txt_mem[s + k]) begin
				s++;
			end else begin
				if (window_equal(s, m))
					mark_start(s);
				s += span;
			end
		end
	endfunction

	function automatic reply_t predict_reply(input kind_t k, input logic [ADDR_W-1:0] a,
			input logic [BYTE_W-1:0] b);
		reply_t r;
		r = '0;
		r.status = ST_OK;
		case (k)
			KIND_PAT: begin
				if (a < PATTERN_MAX_DEF)
					pat_mem[a] = b;
				else
					r.status = ST_RANGE;
			end
			KIND_TEXT: begin
				if (a < TEXT_MAX_DEF)
					txt_mem[a] = b;
				else
					r.status = ST_RANGE;
			end
			KIND_RUN: begin
				scan_text();
			end
			default: begin
				if (a < MAP_WORDS)
					r.word = hit_map[a];
				else
					r.status = ST_RANGE;
			end
		endcase
		r.count = hit_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			pat_len = PLEN_W'(1);
			txt_len = '0;
			hit_total = '0;
			foreach (hit_map[w])
				hit_map[w] = '0;
			reply_q.delete();
			miss_total = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Replies are checked before this edge's request is predicted.
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[0];
				got.count = m_axis_tdata[COUNT_W:1];
				got.word = m_axis_tdata[COUNT_W+WORD_W:COUNT_W+1];
				if (reply_q.size() == 0) begin
					if (miss_total < REPORT_MAX)
						$display("%0t: unexpected reply status=%0d count=%0d word=%h",
							$realtime, got.status, got.count, got.word);
					miss_total++;
				end else begin
					want = reply_q.pop_front();
					if (got.status != want.status || got.count != want.count ||
							got.word != want.word) begin
						if (miss_total < REPORT_MAX)
							$display("%0t: reply mismatch exp status=%0d count=%0d word=%h, got status=%0d count=%0d word=%h",
								$realtime, want.status, want.count, want.word,
								got.status, got.count, got.word);
						miss_total++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_reg_t'(cfg_index) == CFG_PLEN)
					pat_len = cfg_data[PLEN_W-1:0];
				else
					txt_len = cfg_data[TLEN_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				reply_q.push_back(predict_reply(kind_t'(s_axis_tuser),
					s_axis_tdata[ADDR_W-1:0], s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W]));
			fail_count <= miss_total;
			pending <= reply_q.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_tailed_substring_matcher_core.sv @@
`default_nettype none

// Stimulus and verdict for the tailed substring matcher. The checker beside
// the block does all prediction and comparison; this module only produces
// request transactions, the output back-pressure and the configuration
// writes, and decides pass or fail at the end.
module tb_tailed_substring_matcher_core import tsm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_WORDS    = (TEXT_MAX_DEF + 63) / 64;
	localparam int IDLE_PCT     = 37;
	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 4;
	// Searches stay within the loaded part of the text, and the limit on quiet
	// cycles leaves a wide margin over the longest of them, during which no
	// transaction moves at all.
	localparam int QUIET_LIMIT  = 200000;
	// Pattern and text bytes loaded at the start; every search is kept
	// inside these regions.
	localparam int PAT_FILL     = 32;
	localparam int TXT_FILL     = 160;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	kind_t                  s_axis_tuser = KIND_PAT;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	cfg_reg_t               cfg_index = CFG_PLEN;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int   fail_count;
	int   pending;
	int   items_sent = 0;
	logic calm = 1'b0;
	logic stall_go = 1'b0;

	logic [BYTE_W-1:0] pat_fill [PAT_FILL];
	logic [BYTE_W-1:0] cur_pat [8];

	tailed_substring_matcher_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tsm_search_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// Output back-pressure. A pulse on stall_go starts one long hold-off that
	// is counted here, so the sender keeps offering while the block backs up.
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (stall_go)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Ends the run if no transaction moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// Offers one request and returns at the edge where it is taken. Valid is
	// left high on return; the next call either replaces the data in the same
	// step or drops valid for a random gap first.
	task automatic send_item(input kind_t k, input int a, input int b);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(0, 99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - ADDR_W - BYTE_W){1'b0}}, b[BYTE_W-1:0],
			a[ADDR_W-1:0]};
		s_axis_tuser <= k;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stops offering and waits until every predicted reply has come back.
	// The block is then idle, since every request produces exactly one reply.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Only called after drain(), so the block is idle.
	task automatic set_reg(input cfg_reg_t idx, input int v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A well-formed search: new lengths, a short pattern over a tiny alphabet,
	// text bytes from the same alphabet with a planted copy where it fits, then
	// the run and a few bitmap reads. Lengths that make the run scan are
	// kept inside the loaded regions; longer ones only come with an empty
	// pattern or a pattern longer than the text.
	task automatic search_scenario();
		logic [BYTE_W-1:0] sym [3];
		int r, m, n, lo_lim, pos, hi_word;
		foreach (sym[j])
			sym[j] = BYTE_W'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 80)
			m = $urandom_range(1, 6);
		else if (r < 90)
			m = $urandom_range(7, PAT_FILL);
		else if (r < 95)
			m = $urandom_range(PATTERN_MAX_DEF + 1, 511);
		else
			m = 0;
		r = $urandom_range(0, 99);
		if (m == 0)
			n = (r < 50) ? $urandom_range(0, TXT_FILL) : $urandom_range(4000, 8191);
		else if (m > PAT_FILL)
			n = $urandom_range(0, PATTERN_MAX_DEF - 1);
		else
			n = $urandom_range(0, TXT_FILL);
		drain();
		set_reg(CFG_PLEN, m);
		set_reg(CFG_TLEN, n);
		for (int j = 0; j < m && j < 8; j++) begin
			cur_pat[j] = sym[$urandom_range(0, 1)];
			send_item(KIND_PAT, j, cur_pat[j]);
		end
		lo_lim = (n > TXT_FILL) ? TXT_FILL : n;
		if (lo_lim == 0)
			lo_lim = 1;
		repeat ($urandom_range(2, 10))
			send_item(KIND_TEXT, $urandom_range(0, lo_lim - 1), sym[$urandom_range(0, 2)]);
		if (m >= 1 && m <= 8 && lo_lim >= m) begin
			pos = $urandom_range(0, lo_lim - m);
			for (int j = 0; j < m; j++)
				send_item(KIND_TEXT, pos + j, cur_pat[j]);
		end
		// The address and byte of a run transaction carry no meaning.
		send_item(KIND_RUN, $urandom_range(0, 4095), $urandom_range(0, 255));
		hi_word = ((n > TEXT_MAX_DEF) ? TEXT_MAX_DEF : n) / 64;
		repeat ($urandom_range(1, 3))
			send_item(KIND_READ, $urandom_range(0, hi_word), $urandom_range(0, 255));
	endtask

	// Sequences that stop halfway or go out of range.
	task automatic broken_sequence();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) begin
			repeat ($urandom_range(1, 3))
				send_item(KIND_PAT, $urandom_range(PATTERN_MAX_DEF, 4095),
					$urandom_range(0, 255));
			repeat ($urandom_range(1, 3))
				send_item(KIND_PAT, $urandom_range(0, 7), $urandom_range(0, 255));
		end else if (r == 1) begin
			send_item(KIND_RUN, $urandom_range(0, 4095), $urandom_range(0, 255));
			send_item(KIND_READ, $urandom_range(MAP_WORDS, 4095), $urandom_range(0, 255));
			send_item(KIND_READ, $urandom_range(0, MAP_WORDS - 1), $urandom_range(0, 255));
		end else begin
			repeat ($urandom_range(1, 4))
				send_item(KIND_READ, $urandom_range(0, 4095), $urandom_range(0, 255));
		end
	endtask

	initial begin : stimulus
		int base, r, v;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight after reset: a run with an empty text reads no store, and
		// the bitmap reads as zero, including the last word and one past it.
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_READ, MAP_WORDS - 1, 0);
		send_item(KIND_READ, MAP_WORDS, 0);

		// Load the pattern and text regions that later searches scan, so no
		// search touches an entry that was never written. The text holds a
		// copy of the loaded pattern at its start and at its very end.
		pat_fill[0] = 8'hA5;
		for (int j = 1; j < PAT_FILL; j++)
			pat_fill[j] = BYTE_W'($urandom_range(0, 255));
		for (int j = 0; j < PAT_FILL; j++)
			send_item(KIND_PAT, j, pat_fill[j]);
		for (int a = 0; a < TXT_FILL; a++) begin
			if (a < PAT_FILL)
				v = pat_fill[a];
			else if (a >= TXT_FILL - PAT_FILL)
				v = pat_fill[a - (TXT_FILL - PAT_FILL)];
			else
				v = $urandom_range(0, 255);
			send_item(KIND_TEXT, a, v);
		end

		// Pattern writes beyond the store are flagged and dropped.
		send_item(KIND_PAT, PATTERN_MAX_DEF, 8'hFF);
		send_item(KIND_PAT, 4095, 8'h00);

		// Shortest pattern over the whole loaded text.
		drain();
		set_reg(CFG_PLEN, 1);
		set_reg(CFG_TLEN, TXT_FILL);
		send_item(KIND_RUN, 4095, 8'hFF);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_READ, (TXT_FILL - PAT_FILL) / 64, 0);
		send_item(KIND_READ, MAP_WORDS - 1, 0);

		// The loaded pattern is found at the start of the text and at its end.
		drain();
		set_reg(CFG_PLEN, PAT_FILL);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_READ, (TXT_FILL - PAT_FILL) / 64, 0);

		// An empty pattern with a text length above its maximum finds nothing
		// but still clears the bitmap.
		drain();
		set_reg(CFG_PLEN, 0);
		set_reg(CFG_TLEN, 8191);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 0, 0);

		// A pattern length above its maximum is clamped and is still longer
		// than the text, so nothing is found.
		drain();
		set_reg(CFG_PLEN, 511);
		set_reg(CFG_TLEN, PATTERN_MAX_DEF - 1);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 0, 0);

		// A pattern one byte longer than the text finds nothing.
		drain();
		set_reg(CFG_PLEN, PAT_FILL);
		set_reg(CFG_TLEN, PAT_FILL - 1);
		send_item(KIND_RUN, 0, 0);

		// Pattern and text of equal length: a single window.
		drain();
		set_reg(CFG_TLEN, PAT_FILL);
		send_item(KIND_RUN, 0, 0);
		send_item(KIND_READ, 0, 0);
		send_item(KIND_READ, 4095, 0);

		// Hold the output off for a long stretch while requests keep coming,
		// so the block fills up and stops taking transactions.
		s_axis_tvalid <= 1'b0;
		stall_go <= 1'b1;
		@(posedge clk);
		stall_go <= 1'b0;
		repeat (40)
			send_item(KIND_TEXT, $urandom_range(0, TXT_FILL - 1), $urandom_range(0, 255));
		drain();

		base = items_sent;
		foreach (cur_pat[j])
			cur_pat[j] = '0;
		while (items_sent - base < RANDOM_ITEMS) begin
			// One stretch in the middle runs with no idling on either side.
			calm <= (items_sent - base >= 120 && items_sent - base < 200);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				search_scenario();
			end else if (r < 85) begin
				repeat ($urandom_range(1, 6))
					send_item(kind_t'($urandom_range(0, 3)), $urandom_range(0, 4095),
						$urandom_range(0, 255));
			end else begin
				broken_sequence();
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
